// ===== hdl/rzc_pkg.sv =====
// ----------------------------------------------------------------------------
// rzc_pkg
// Types and codes shared by the repeated z-score combiner.
// ----------------------------------------------------------------------------
`default_nettype none

package rzc_pkg;

  localparam logic [1:0] REG_MAX_SAMPLES  = 2'd0;
  localparam logic [1:0] REG_Z_LIMIT      = 2'd1;
  localparam logic [1:0] REG_LIMIT_ENABLE = 2'd2;

  localparam logic [1:0] VERDICT_NEUTRAL = 2'd0;
  localparam logic [1:0] VERDICT_UNLUCKY = 2'd1;
  localparam logic [1:0] VERDICT_LUCKY   = 2'd2;

  localparam logic [31:0] MAX_SAMPLES_RESET  = 32'd1000000;
  localparam logic [30:0] Z_LIMIT_RESET      = 31'd655360;
  localparam logic        LIMIT_ENABLE_RESET = 1'b1;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [15:0]        sub_df;
    logic signed [31:0] sub_z;
    logic               first_of_run;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] combined_z_out;
    logic [39:0]        total_df_out;
    logic [31:0]        sample_index;
    logic               run_stopped;
    logic [1:0]         verdict;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/rzc_chan_if.sv =====
// ----------------------------------------------------------------------------
// rzc_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rzc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/repeated_zscore_combiner.sv =====
// ----------------------------------------------------------------------------
// repeated_zscore_combiner
// Folds sub-test z-scores into a running combined z with bit-serial roots.
//
//   channel   | dir | payload
//   ----------+-----+------------------------------------------
//   cfg       | in  | index, data (register write)
//   samples   | in  | sub_df, sub_z, first_of_run
//   results   | out | combined_z_out, total_df_out, sample_index,
//             |     | run_stopped, verdict
//
// A combining item makes four passes of the serial root unit and two of the
// serial squarer. Copied and ignored items skip both units and go straight
// to the finish state.
// Reset idles the run until a first_of_run item arrives.
// One item is in flight at a time; a held result stalls only the next finish.
// ----------------------------------------------------------------------------
`default_nettype none

module repeated_zscore_combiner
  import rzc_pkg::*;
#(
  parameter int Z_FRAC_BITS = 16,
  parameter int DF_ACC_BITS = 40
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rzc_chan_if.sink    cfg,
  rzc_chan_if.sink    samples,
  rzc_chan_if.source  results
);
  localparam int DW   = DF_ACC_BITS + 1;
  localparam int HRAD = DW + 2 * Z_FRAC_BITS;
  localparam int HRW  = (HRAD + 1) / 2;
  localparam int MW   = ((HRW > 31) ? HRW : 31) + 1;
  localparam int SQW  = 2 * MW + 1;
  localparam int NWR  = (HRAD > SQW) ? HRAD : SQW;
  localparam int NW   = NWR + (NWR % 2);
  localparam int RW   = NW / 2;
  localparam int DFX  = (DF_ACC_BITS > 40) ? DF_ACC_BITS : 40;

  localparam logic signed [RW:0] ZMAX = (RW+1)'(64'sh7fffffff);
  localparam logic signed [RW:0] ZMIN = (RW+1)'(-64'sh80000000);

  typedef enum logic [2:0] {
    S_IDLE, S_HRA, S_SQA, S_HRB, S_SQB, S_ROOT, S_HRS, S_FIN
  } state_t;

  state_t state;

  logic [31:0]          max_samples;
  logic [30:0]          z_limit;
  logic                 limit_enable;

  logic signed [31:0]   acc_z;
  logic [DF_ACC_BITS-1:0] acc_df;
  logic [31:0]          count;
  logic                 stopped;
  logic                 live;
  logic [15:0]          di;
  logic signed [31:0]   zi;
  logic                 launch;
  logic [MW-1:0]        op_mag;
  logic [NW-1:0]        sumsq;
  logic [RW-1:0]        s1;
  out_item_t            out_item;
  logic                 out_valid;

  logic [DW-1:0]        d_sel;
  logic [DW:0]          d_dbl;
  logic [NW-1:0]        rad_hr;
  logic [NW-1:0]        radicand;
  logic                 sq_done;
  logic [RW-1:0]        root;
  logic                 mul_done;
  logic [2*MW-1:0]      product;
  logic [DW-1:0]        df_sum;
  logic signed [MW:0]   addend;
  logic signed [MW:0]   a_sum;
  logic signed [MW:0]   a_neg;
  logic signed [RW:0]   z_wide;
  logic [32:0]          z_mag;
  logic signed [32:0]   z_ext;
  logic signed [32:0]   lim_ext;
  logic                 stop_now;
  logic                 stopped_new;
  logic [1:0]           verdict;
  logic [DFX-1:0]       df_ext;
  logic [39:0]          df_out;
  logic                 in_take;
  in_item_t             it;

  assign it       = samples.payload;
  assign in_take  = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;
  assign results.valid   = out_valid;
  assign results.payload = out_item;

  assign df_sum = DW'(acc_df) + DW'(di);

  always_comb begin
    unique case (state)
      S_HRA:   d_sel = DW'(acc_df);
      S_HRB:   d_sel = DW'(di);
      default: d_sel = df_sum;
    endcase
    d_dbl  = {d_sel, 1'b0} - (DW+1)'(1);
    rad_hr = (d_sel == '0) ? '0 : (NW'(d_dbl) << (2 * Z_FRAC_BITS - 1));
    radicand = (state == S_ROOT) ? sumsq : rad_hr;
  end

  rzc_sqrt #(.NW(NW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (launch && (state == S_HRA || state == S_HRB ||
                          state == S_ROOT || state == S_HRS)),
    .radicand (radicand),
    .done     (sq_done),
    .root     (root)
  );

  rzc_square #(.MW(MW)) u_square (
    .clk     (clk),
    .rst     (rst),
    .start   (launch && (state == S_SQA || state == S_SQB)),
    .operand (op_mag),
    .done    (mul_done),
    .product (product)
  );

  always_comb begin
    addend = (state == S_HRA) ? (MW+1)'(acc_z) : (MW+1)'(zi);
    a_sum  = addend + $signed({1'b0, root[MW-1:0]});
    a_neg  = -a_sum;
    z_wide = $signed({1'b0, s1}) - $signed({1'b0, root});
    z_ext  = 33'(acc_z);
    z_mag  = z_ext[32] ? 33'(-z_ext) : 33'(z_ext);
    lim_ext = $signed({2'b00, z_limit});
    stop_now = (limit_enable && (z_mag >= {2'b00, z_limit})) ||
               ((max_samples != '0) && (count >= max_samples));
    stopped_new = stopped || (live && stop_now);
    verdict = VERDICT_NEUTRAL;
    if (limit_enable) begin
      if (z_ext < -lim_ext) verdict = VERDICT_UNLUCKY;
      else if (z_ext > lim_ext) verdict = VERDICT_LUCKY;
    end
    df_ext = DFX'(acc_df);
    df_out = (df_ext > DFX'({40{1'b1}})) ? {40{1'b1}} : df_ext[39:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launch       <= 1'b0;
      out_valid    <= 1'b0;
      max_samples  <= MAX_SAMPLES_RESET;
      z_limit      <= Z_LIMIT_RESET;
      limit_enable <= LIMIT_ENABLE_RESET;
      acc_z        <= '0;
      acc_df       <= '0;
      count        <= '0;
      stopped      <= 1'b1;
      live         <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (results.valid && results.ready) out_valid <= 1'b0;
      if (cfg.valid) begin
        unique case (cfg.payload.index)
          REG_MAX_SAMPLES:  max_samples  <= cfg.payload.data;
          REG_Z_LIMIT:      z_limit      <= cfg.payload.data[30:0];
          REG_LIMIT_ENABLE: limit_enable <= cfg.payload.data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            di <= it.sub_df;
            zi <= it.sub_z;
            if (it.first_of_run || !stopped) begin
              live <= 1'b1;
              stopped <= 1'b0;
              if (it.first_of_run) count <= 32'd1;
              else if (count != '1) count <= count + 32'd1;
              if (it.first_of_run || acc_df == '0) begin
                acc_z  <= it.sub_z;
                acc_df <= DF_ACC_BITS'(it.sub_df);
                state  <= S_FIN;
              end else begin
                state  <= S_HRA;
                launch <= 1'b1;
              end
            end else begin
              live  <= 1'b0;
              state <= S_FIN;
            end
          end
        end
        S_HRA: if (sq_done) begin
          op_mag <= a_sum[MW] ? a_neg[MW-1:0] : a_sum[MW-1:0];
          state  <= S_SQA;
          launch <= 1'b1;
        end
        S_SQA: if (mul_done) begin
          sumsq  <= NW'(product);
          state  <= S_HRB;
          launch <= 1'b1;
        end
        S_HRB: if (sq_done) begin
          op_mag <= a_sum[MW] ? a_neg[MW-1:0] : a_sum[MW-1:0];
          state  <= S_SQB;
          launch <= 1'b1;
        end
        S_SQB: if (mul_done) begin
          sumsq  <= sumsq + NW'(product);
          state  <= S_ROOT;
          launch <= 1'b1;
        end
        S_ROOT: if (sq_done) begin
          s1     <= root;
          state  <= S_HRS;
          launch <= 1'b1;
        end
        S_HRS: if (sq_done) begin
          if (z_wide > ZMAX) acc_z <= 32'sh7fffffff;
          else if (z_wide < ZMIN) acc_z <= -32'sh80000000;
          else acc_z <= z_wide[31:0];
          acc_df <= df_sum[DW-1] ? '1 : df_sum[DF_ACC_BITS-1:0];
          state  <= S_FIN;
        end
        S_FIN: if (!out_valid || results.ready) begin
          stopped   <= stopped_new;
          out_valid <= 1'b1;
          out_item.combined_z_out <= acc_z;
          out_item.total_df_out   <= df_out;
          out_item.sample_index   <= count;
          out_item.run_stopped    <= stopped_new;
          out_item.verdict        <= verdict;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

`default_nettype wire

// ===== hdl/rzc_sqrt.sv =====
// ----------------------------------------------------------------------------
// rzc_sqrt
// Restoring integer square root, one root bit per cycle (floor).
// ----------------------------------------------------------------------------
`default_nettype none

module rzc_sqrt #(
  parameter int NW = 78
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] radicand,
  output logic               done,
  output logic [NW/2-1:0]    root
);
  localparam int RW = NW / 2;
  localparam int CW = $clog2(RW + 1);

  logic [NW-1:0] rad;
  logic [RW:0]   rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [RW+2:0] rem_sh;
  logic [RW+3:0] diff;

  assign rem_sh = {rem, rad[NW-1:NW-2]};
  assign diff   = {1'b0, rem_sh} - {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(RW);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[NW-3:0], 2'b00};
        if (!diff[RW+3]) begin
          rem  <= diff[RW:0];
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[RW:0];
          root <= {root[RW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

`default_nettype wire

// ===== hdl/rzc_square.sv =====
// ----------------------------------------------------------------------------
// rzc_square
// Shift-add squarer, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rzc_square #(
  parameter int MW = 38
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [MW-1:0] operand,
  output logic               done,
  output logic [2*MW-1:0]    product
);
  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0] m;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [MW:0]   hi_sum;

  assign hi_sum = {1'b0, product[2*MW-1:MW]} + (product[0] ? {1'b0, m} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CW'(MW);
        m       <= operand;
        product <= {{MW{1'b0}}, operand};
      end else if (busy) begin
        product <= {hi_sum, product[MW-1:1]};
        cnt     <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

`default_nettype wire

// ===== dv/repeated_zscore_combiner_tb.sv =====
// ----------------------------------------------------------------------------
// repeated_zscore_combiner_tb
// Drives sub-test results through the combiner under several register
// settings and random handshake pressure, and checks every result against
// a bit-exact predictor of the running combined z, total df, count, stop
// flag and verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module repeated_zscore_combiner_tb;
  import rzc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ZF         = 16;
  localparam int  DF_BITS    = 40;
  localparam int  CYCLE_CAP  = 6000000;
  localparam int  HOLD_LEN   = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rzc_chan_if #(.payload_t(cfg_item_t)) cfg_ch ();
  rzc_chan_if #(.payload_t(in_item_t))  sample_ch ();
  rzc_chan_if #(.payload_t(out_item_t)) result_ch ();

  repeated_zscore_combiner dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch.sink),
    .samples (sample_ch.sink),
    .results (result_ch.source)
  );

  always #4 clk = ~clk;

  in_item_t  pending_q[$];
  out_item_t expected_q[$];
  int        errors = 0;
  int        cycles = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  logic      sample_fire = 1'b0;
  int        hold_left = 0;
  logic      hold_go = 1'b0;
  logic      hold_done = 1'b0;

  // Mirror of the block's registers and run state
  logic [31:0] mir_max_samples;
  logic [30:0] mir_z_limit;
  logic        mir_limit_en;
  longint      run_z;
  logic [63:0] run_df;
  logic [31:0] run_count;
  logic        run_halted;

  function automatic logic [63:0] floor_root(input logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] half_root(input logic [63:0] d);
    logic [127:0] n;
    if (d == 0) return 64'd0;
    n = {64'd0, 64'(2 * d - 1)} << (2 * ZF - 1);
    return floor_root(n);
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic out_item_t combine_sample(input in_item_t s);
    out_item_t    r;
    longint       zi, a, b, diff;
    logic [63:0]  ma, mb, s1, s2, df_cap;
    logic [127:0] radicand;
    zi = longint'(s.sub_z);
    df_cap = (64'd1 << DF_BITS) - 1;
    if (s.first_of_run) begin
      run_z = 0;
      run_df = 0;
      run_count = 0;
      run_halted = 1'b0;
    end
    if (!run_halted) begin
      if (run_count != 32'hFFFF_FFFF) run_count++;
      if (run_df == 0) begin
        run_df = 64'(s.sub_df);
        run_z = zi;
      end else begin
        a = run_z + longint'(half_root(run_df));
        b = zi + longint'(half_root(64'(s.sub_df)));
        ma = magnitude(a);
        mb = magnitude(b);
        radicand = {64'd0, ma} * {64'd0, ma} + {64'd0, mb} * {64'd0, mb};
        s1 = floor_root(radicand);
        s2 = half_root(run_df + 64'(s.sub_df));
        diff = longint'(s1) - longint'(s2);
        if (diff > 64'sd2147483647) diff = 64'sd2147483647;
        if (diff < -64'sd2147483648) diff = -64'sd2147483648;
        run_z = diff;
        run_df = run_df + 64'(s.sub_df);
        if (run_df > df_cap) run_df = df_cap;
      end
      if (mir_limit_en && magnitude(run_z) >= 64'(mir_z_limit)) run_halted = 1'b1;
      if (mir_max_samples != 0 && run_count >= mir_max_samples) run_halted = 1'b1;
    end
    r.verdict = VERDICT_NEUTRAL;
    if (mir_limit_en) begin
      if (run_z < -longint'(mir_z_limit)) r.verdict = VERDICT_UNLUCKY;
      else if (run_z > longint'(mir_z_limit)) r.verdict = VERDICT_LUCKY;
    end
    r.combined_z_out = run_z[31:0];
    r.total_df_out = run_df[39:0];
    r.sample_index = run_count;
    r.run_stopped = run_halted;
    return r;
  endfunction

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    sample_ch.valid = 1'b0;
    sample_ch.payload = '0;
    result_ch.ready = 1'b0;
    mir_max_samples = MAX_SAMPLES_RESET;
    mir_z_limit = Z_LIMIT_RESET;
    mir_limit_en = LIMIT_ENABLE_RESET;
    run_z = 0;
    run_df = 0;
    run_count = 0;
    run_halted = 1'b1;
  end

  // Sender
  always @(negedge clk) begin
    if (!rst && (!sample_ch.valid || sample_fire)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        sample_ch.payload <= pending_q.pop_front();
        sample_ch.valid <= 1'b1;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk) begin
    if (rst) result_ch.ready <= 1'b0;
    else result_ch.ready <= hold_left == 0 && $urandom_range(99) >= rx_idle_pct;
  end

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor and checker
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
    sample_fire <= sample_ch.valid && sample_ch.ready;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.payload.index)
          REG_MAX_SAMPLES:  mir_max_samples = cfg_ch.payload.data;
          REG_Z_LIMIT:      mir_z_limit = cfg_ch.payload.data[30:0];
          REG_LIMIT_ENABLE: mir_limit_en = cfg_ch.payload.data[0];
          default: ;
        endcase
      end
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.combined_z_out !== want.combined_z_out) begin
            $display("%0t: combined_z exp %0d got %0d", $time, want.combined_z_out,
                     got.combined_z_out);
            errors++;
          end
          if (got.total_df_out !== want.total_df_out) begin
            $display("%0t: total_df exp %0d got %0d", $time, want.total_df_out,
                     got.total_df_out);
            errors++;
          end
          if (got.sample_index !== want.sample_index) begin
            $display("%0t: sample_index exp %0d got %0d", $time, want.sample_index,
                     got.sample_index);
            errors++;
          end
          if (got.run_stopped !== want.run_stopped) begin
            $display("%0t: run_stopped exp %0b got %0b", $time, want.run_stopped,
                     got.run_stopped);
            errors++;
          end
          if (got.verdict !== want.verdict) begin
            $display("%0t: verdict exp %0d got %0d", $time, want.verdict, got.verdict);
            errors++;
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready)
        expected_q.push_back(combine_sample(sample_ch.payload));
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_ch.payload <= '{index: idx, data: value};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || sample_ch.valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_item(input logic [15:0] df, input logic [31:0] z, input logic first);
    in_item_t s;
    s.sub_df = df;
    s.sub_z = z;
    s.first_of_run = first;
    pending_q.push_back(s);
  endtask

  function automatic logic [31:0] pick_z();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 6 << ZF)) - (32'd3 << ZF);
    endcase
  endfunction

  function automatic logic [15:0] pick_df();
    case ($urandom_range(9))
      0:       return 16'($urandom());
      1:       return 16'd0;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  task automatic add_runs(input int n);
    int left;
    int len;
    left = n;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        add_item(pick_df(), pick_z(), $urandom_range(1));
        left--;
      end else begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) add_item(pick_df(), pick_z(), k == 0);
        left -= len;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset registers, idle items, field extremes
    add_item(16'd5, 32'd100, 1'b0);
    add_item(16'd1, 32'h7FFF_FFFF, 1'b1);
    add_item(16'd1, 32'd0, 1'b0);
    add_item(16'd0, 32'h8000_0000, 1'b1);
    add_item(16'd0, 32'd65536, 1'b0);
    add_item(16'hFFFF, 32'hFFFF_0000, 1'b0);
    add_item(16'hFFFF, 32'h0001_8000, 1'b0);
    add_item(16'd3, 32'h0002_0000, 1'b0);
    add_item(16'hFFFF, 32'h8000_0000, 1'b1);
    add_item(16'hFFFF, 32'h8000_0000, 1'b0);
    add_item(16'd2, 32'h7FFF_FFFF, 1'b0);
    drain();
    write_reg(REG_Z_LIMIT, 32'd0);
    write_reg(REG_MAX_SAMPLES, 32'd0);
    add_item(16'd7, 32'd0, 1'b1);
    add_item(16'd7, 32'd5, 1'b0);
    drain();
    write_reg(REG_LIMIT_ENABLE, 32'd0);
    write_reg(REG_Z_LIMIT, 32'h7FFF_FFFF);
    add_item(16'd1, 32'h7FFF_FFFF, 1'b1);
    for (int k = 0; k < 6; k++) add_item(16'hFFFF, 32'h7FFF_FFFF, 1'b0);
    add_item(16'hFFFF, 32'h8000_0000, 1'b0);
    drain();

    // Random: sender 25, receiver 75, with a long receiver stall
    write_reg(REG_LIMIT_ENABLE, 32'd1);
    write_reg(REG_Z_LIMIT, 32'd3 << ZF);
    write_reg(REG_MAX_SAMPLES, 32'd5);
    tx_idle_pct = 25;
    rx_idle_pct = 75;
    add_runs(150);
    hold_go = 1'b1;
    add_runs(150);
    drain();

    write_reg(REG_MAX_SAMPLES, 32'hFFFF_FFFF);
    write_reg(REG_Z_LIMIT, 32'd1 << ZF);
    tx_idle_pct = 75;
    rx_idle_pct = 25;
    add_runs(300);
    drain();

    write_reg(REG_MAX_SAMPLES, 32'd1);
    write_reg(REG_LIMIT_ENABLE, 32'd0);
    add_runs(60);
    drain();

    write_reg(REG_MAX_SAMPLES, 32'd8);
    write_reg(REG_LIMIT_ENABLE, 32'd1);
    write_reg(REG_Z_LIMIT, 32'h7FFF_FFFF);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    add_runs(200);
    drain();
    write_reg(REG_Z_LIMIT, 32'd2 << ZF);
    write_reg(REG_MAX_SAMPLES, 32'd0);
    add_runs(150);
    drain();
    repeat (400) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== repeated_zscore_combiner.f =====
hdl/rzc_pkg.sv
hdl/rzc_chan_if.sv
hdl/rzc_sqrt.sv
hdl/rzc_square.sv
hdl/repeated_zscore_combiner.sv
dv/repeated_zscore_combiner_tb.sv
